@@ hdl/sh3_pkg.sv @@
// shared types and constants for the 3x3 sharpening convolution
package sh3_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int PixW      = 16;
  localparam int DimW      = 11;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = DimW + 1;
  localparam int SumW      = PixW + 4;

  localparam logic [DimW-1:0] DimMaxW = DimW'(MaxWidth);
  localparam logic [DimW-1:0] DimMaxH = DimW'(MaxHeight);

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam logic REG_ACTIVE_WIDTH  = 1'b0;
  localparam logic REG_ACTIVE_HEIGHT = 1'b1;

  typedef logic signed [PixW-1:0] pix_t;
  typedef pix_t [2:0] pix_col_t;

  // per-beat control carried down the pipeline
  typedef struct packed {
    logic [ColW-1:0] col;
    pix_t            v;
    logic            has_res;
    logic            top_ok;
    logic            bot_ok;
    logic            left_ok;
    logic            right_ok;
    logic            last;
  } sh3_ctl_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] val,
                                                 input logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    if (val == '0) begin
      r = DimW'(1);
    end else if (val > maxv) begin
      r = maxv;
    end else begin
      r = val;
    end
    return r;
  endfunction

endpackage

@@ hdl/sh3_in_if.sv @@
// input channel: pixel or drain beat
interface sh3_in_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [15:0]       pixel;

  modport source (output valid, req_type, pixel, input ready);
  modport sink   (input valid, req_type, pixel, output ready);
endinterface

@@ hdl/sh3_out_if.sv @@
// output channel: sharpened pixel
interface sh3_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [15:0]       out_pixel;
  logic                     last_of_frame;

  modport source (output valid, out_pixel, last_of_frame, input ready);
  modport sink   (input valid, out_pixel, last_of_frame, output ready);
endinterface

@@ hdl/sh3_line_mem.sv @@
// line store memory: upper and middle rows side by side, registered read
module sh3_line_mem (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [sh3_pkg::ColW-1:0]       rd_addr,
  output logic [2*sh3_pkg::PixW-1:0]     rd_data,
  input  logic                           wr_en,
  input  logic [sh3_pkg::ColW-1:0]       wr_addr,
  input  logic [2*sh3_pkg::PixW-1:0]     wr_data
);
  import sh3_pkg::*;

  logic [2*PixW-1:0] mem [MaxWidth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

@@ hdl/sh3_cell.sv @@
// one window column of three pixels, handed to the left neighbour on each shift
module sh3_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  sh3_pkg::pix_col_t col_in,
  output sh3_pkg::pix_col_t col_out
);
  import sh3_pkg::*;

  pix_col_t col;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;
endmodule

@@ hdl/sharpen_convolution_3x3_unit.sv @@
// 3x3 sharpening convolution over a raster pixel stream
// the result a beat releases (if any) is offered from the output register, behind stages 1 and 2
// throughput: one beat per cycle, sustained, limited only by output back-pressure
// the line store is one dual-port memory, read when a beat is taken, with write forwarding
// reset: synchronous, clears position, window and pipeline; width and height go to 1024
// line store contents are left as they are at reset and need no clearing pass
module sharpen_convolution_3x3_unit (
  input  logic                       clk,
  input  logic                       rst,
  sh3_in_if.sink                     in_ch,
  sh3_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [sh3_pkg::DimW-1:0]   cfg_data
);
  import sh3_pkg::*;

  logic [DimW-1:0] act_w;
  logic [DimW-1:0] act_h;
  logic [ColW-1:0] col;
  logic [RowW-1:0] row;

  logic adv;
  logic acc;

  // stage 1: memory read in flight
  logic            s1_valid;
  sh3_ctl_t        s1_ctl;
  logic            fwd_hit;
  logic [2*PixW-1:0] fwd_data;
  logic [2*PixW-1:0] mem_q;
  logic [2*PixW-1:0] mem_eff;

  // stage 2: window holds the beat's neighbourhood
  logic            s2_valid;
  sh3_ctl_t        s2_ctl;

  logic            out_valid;
  pix_t            out_pix;
  logic            out_last;

  sh3_ctl_t        ctl_next;
  logic [RowW-1:0] r1;
  logic [DimW-1:0] col_inc;
  pix_col_t        col_new;
  pix_col_t        win0;
  pix_col_t        win1;
  pix_col_t        win2;
  logic [SumW-1:0] sum;

  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign acc         = in_ch.valid && adv;

  // position of the window centre for the incoming beat
  always_comb begin
    ctl_next = '0;
    ctl_next.col = col;
    if (row < RowW'(act_h) && in_ch.req_type == REQ_PIXEL) begin
      ctl_next.v = in_ch.pixel;
    end
    r1 = (col != '0) ? row : row - RowW'(1);
    ctl_next.has_res = !(col == '0 && row == '0) && (r1 >= RowW'(1)) && (r1 <= RowW'(act_h));
    ctl_next.top_ok  = r1 >= RowW'(2);
    ctl_next.bot_ok  = r1 < RowW'(act_h);
    if (col != '0) begin
      ctl_next.left_ok  = col >= ColW'(2);
      ctl_next.right_ok = 1'b1;
      ctl_next.last     = (r1 == RowW'(act_h)) && (DimW'(col) == act_w);
    end else begin
      ctl_next.left_ok  = act_w >= DimW'(2);
      ctl_next.right_ok = 1'b0;
      ctl_next.last     = r1 == RowW'(act_h);
    end
    col_inc = DimW'(col) + DimW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_w <= DimMaxW;
      act_h <= DimMaxH;
      col   <= '0;
      row   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_WIDTH:  act_w <= clamp_dim(cfg_data, DimMaxW);
        REG_ACTIVE_HEIGHT: act_h <= clamp_dim(cfg_data, DimMaxH);
        default:           act_w <= act_w;
      endcase
      col <= '0;
      row <= '0;
    end else if (acc) begin
      priority if (ctl_next.has_res && ctl_next.last) begin
        col <= '0;
        row <= '0;
      end else if (col_inc >= act_w) begin
        col <= '0;
        row <= row + RowW'(1);
      end else begin
        col <= col_inc[ColW-1:0];
      end
    end
  end

  sh3_line_mem u_mem (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (col),
    .rd_data (mem_q),
    .wr_en   (adv && s1_valid),
    .wr_addr (s1_ctl.col),
    .wr_data ({mem_eff[PixW-1:0], s1_ctl.v})
  );

  // the beat in stage 1 writes the same column that the new beat reads when the width is one
  // or when a frame starts again right behind its last beat
  assign mem_eff = fwd_hit ? fwd_data : mem_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (adv) begin
      s1_valid <= acc;
      s2_valid <= s1_valid;
      fwd_hit  <= acc && s1_valid && (s1_ctl.col == col);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl   <= ctl_next;
      fwd_data <= {mem_eff[PixW-1:0], s1_ctl.v};
      s2_ctl   <= s1_ctl;
    end
  end

  // window: element 0 is the top row
  assign col_new = {s1_ctl.v, mem_eff[PixW-1:0], mem_eff[2*PixW-1:PixW]};

  sh3_cell u_cell2 (
    .clk (clk), .rst (rst), .shift (adv && s1_valid), .col_in (col_new), .col_out (win2)
  );
  sh3_cell u_cell1 (
    .clk (clk), .rst (rst), .shift (adv && s1_valid), .col_in (win2), .col_out (win1)
  );
  sh3_cell u_cell0 (
    .clk (clk), .rst (rst), .shift (adv && s1_valid), .col_in (win1), .col_out (win0)
  );

  // nine taps: nine times the centre less the neighbours inside the image
  always_comb begin
    sum = (SumW'(win1[1]) << 3) + SumW'(win1[1]);
    if (s2_ctl.top_ok) begin
      sum = sum - SumW'(win1[0]);
      if (s2_ctl.left_ok)  sum = sum - SumW'(win0[0]);
      if (s2_ctl.right_ok) sum = sum - SumW'(win2[0]);
    end
    if (s2_ctl.bot_ok) begin
      sum = sum - SumW'(win1[2]);
      if (s2_ctl.left_ok)  sum = sum - SumW'(win0[2]);
      if (s2_ctl.right_ok) sum = sum - SumW'(win2[2]);
    end
    if (s2_ctl.left_ok)  sum = sum - SumW'(win0[1]);
    if (s2_ctl.right_ok) sum = sum - SumW'(win2[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid && s2_ctl.has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix  <= pix_t'(sum[PixW-1:0]);
      out_last <= s2_ctl.last;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.out_pixel     = out_pix;
  assign out_ch.last_of_frame = out_last;
endmodule

@@ verif/tb_sharpen_convolution_3x3_unit.sv @@
// testbench for the 3x3 sharpening convolution unit: directed and random frames, self-checking
`timescale 1ns / 1ps

module tb_sharpen_convolution_3x3_unit;
  import sh3_pkg::*;

  typedef struct packed {
    pix_t out_pixel;
    logic last_of_frame;
  } sharpened_t;

  logic            clk = 1'b0;
  logic            rst;
  logic            cfg_we;
  logic            cfg_index;
  logic [DimW-1:0] cfg_data;

  sh3_in_if  in_ch();
  sh3_out_if out_ch();

  sharpen_convolution_3x3_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  pix_t upper_row_mem [MaxWidth];
  pix_t middle_row_mem [MaxWidth];
  pix_t tap_window [3][3];
  int   at_col;
  int   at_row;
  int   width_now;
  int   height_now;

  sharpened_t sharpened_due [$];
  sharpened_t head_res;

  int fail_count   = 0;
  int beats_sent   = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int rx_hold_left = 0;

  always #2 clk = ~clk;

  function automatic void apply_dim(input logic idx, input logic [DimW-1:0] val);
    int dim;
    dim = (val == '0) ? 1 : int'(val);
    if (idx == REG_ACTIVE_WIDTH) begin
      width_now = (dim > MaxWidth) ? MaxWidth : dim;
    end else begin
      height_now = (dim > MaxHeight) ? MaxHeight : dim;
    end
    at_col = 0;
    at_row = 0;
  endfunction

  function automatic void predict_sharpened(input logic kind, input pix_t px);
    int         col;
    int         cr;
    int         cc;
    int         rr;
    int         kk;
    int         acc;
    pix_t       v;
    sharpened_t res;
    col = at_col;
    // beats past the last row are drains whatever their type
    v = (at_row < height_now && kind == REQ_PIXEL) ? px : '0;
    for (int r = 0; r < 3; r++) begin
      tap_window[r][0] = tap_window[r][1];
      tap_window[r][1] = tap_window[r][2];
    end
    tap_window[0][2] = upper_row_mem[col];
    tap_window[1][2] = middle_row_mem[col];
    tap_window[2][2] = v;
    upper_row_mem[col] = middle_row_mem[col];
    middle_row_mem[col] = v;
    // a beat at column zero releases the last centre of the row before
    if (col >= 1) begin
      cr = at_row - 1;
      cc = col - 1;
    end else begin
      cr = at_row - 2;
      cc = width_now - 1;
    end
    at_col++;
    if (at_col >= width_now) begin
      at_col = 0;
      at_row++;
    end
    if (cr < 0 || cr >= height_now) return;
    acc = 9 * tap_window[1][1];
    for (int r = 0; r < 3; r++) begin
      rr = cr + r - 1;
      for (int k = 0; k < 3; k++) begin
        kk = cc + k - 1;
        if (rr >= 0 && rr < height_now && kk >= 0 && kk < width_now && !(r == 1 && k == 1))
          acc -= tap_window[r][k];
      end
    end
    res.out_pixel     = acc[PixW-1:0];
    res.last_of_frame = (cr == height_now - 1) && (cc == width_now - 1);
    sharpened_due.push_back(res);
    if (res.last_of_frame) begin
      at_col = 0;
      at_row = 0;
    end
  endfunction

  function automatic pix_t random_pixel();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return pix_t'(int'($urandom_range(8)) - 4);
      default: return pix_t'($urandom);
    endcase
  endfunction

  // returns at the rising edge that took the beat
  task automatic send_beat(input logic kind, input pix_t px);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.req_type = kind;
    in_ch.pixel    = px;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predict_sharpened(kind, px);
    beats_sent++;
  endtask

  task automatic send_frame(input int pix_count, input int drain_count, input int noise_pct);
    for (int i = 0; i < pix_count; i++)
      send_beat(($urandom_range(99) < noise_pct) ? REQ_DRAIN : REQ_PIXEL, random_pixel());
    for (int i = 0; i < drain_count; i++)
      send_beat(($urandom_range(99) < noise_pct) ? REQ_PIXEL : REQ_DRAIN, pix_t'($urandom));
  endtask

  // sender stops until every expected result is out, then allows for beats still in flight
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sharpened_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_dim(input logic idx, input logic [DimW-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    apply_dim(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_directed_extremes();
    wait_idle();
    write_dim(REG_ACTIVE_WIDTH, DimW'(3));
    write_dim(REG_ACTIVE_HEIGHT, DimW'(3));
    send_beat(REQ_PIXEL, 16'sh7fff);
    send_beat(REQ_PIXEL, 16'sh8000);
    send_beat(REQ_PIXEL, 16'sh7fff);
    send_beat(REQ_PIXEL, 16'sh7fff);
    send_beat(REQ_PIXEL, 16'sh8000);
    send_beat(REQ_PIXEL, 16'sh7fff);
    // drain before the frame is in: taken as a zero pixel
    send_beat(REQ_DRAIN, 16'sh7fff);
    send_beat(REQ_PIXEL, 16'sh0001);
    send_beat(REQ_PIXEL, -16'sh0001);
    send_beat(REQ_DRAIN, 16'sh0000);
    // pixel after the frame is in: taken as a drain
    send_beat(REQ_PIXEL, 16'sh1234);
    send_beat(REQ_DRAIN, -16'sh0001);
    send_beat(REQ_DRAIN, 16'sh5555);
    wait_idle();
    write_dim(REG_ACTIVE_WIDTH, DimW'(1));
    write_dim(REG_ACTIVE_HEIGHT, DimW'(1));
    send_beat(REQ_PIXEL, 16'sh8000);
    send_frame(0, 2, 0);
    wait_idle();
    write_dim(REG_ACTIVE_WIDTH, DimW'(2));
    send_beat(REQ_PIXEL, 16'sh7fff);
    send_beat(REQ_PIXEL, -16'sh0001);
    send_frame(0, 3, 0);
  endtask

  task automatic test_mid_frame_restart();
    wait_idle();
    write_dim(REG_ACTIVE_WIDTH, DimW'(5));
    write_dim(REG_ACTIVE_HEIGHT, DimW'(4));
    send_frame(12, 0, 0);
    wait_idle();
    write_dim(REG_ACTIVE_HEIGHT, DimW'(4));
    send_frame(10, 0, 0);
    wait_idle();
    send_frame(10, 6, 0);
  endtask

  task automatic test_back_to_back_frames();
    wait_idle();
    write_dim(REG_ACTIVE_WIDTH, DimW'(4));
    write_dim(REG_ACTIVE_HEIGHT, DimW'(3));
    repeat (3) send_frame(12, 5, 2);
  endtask

  task automatic test_input_stall();
    wait_idle();
    write_dim(REG_ACTIVE_WIDTH, DimW'(20));
    write_dim(REG_ACTIVE_HEIGHT, DimW'(4));
    send_frame(30, 0, 0);
    // long receiver hold-off while beats keep coming
    rx_hold_left = 150;
    send_frame(50, 21, 0);
  endtask

  task automatic test_dimension_clamping();
    wait_idle();
    write_dim(REG_ACTIVE_WIDTH, DimW'(0));
    write_dim(REG_ACTIVE_HEIGHT, DimW'(2047));
    send_frame(20, 0, 0);
    wait_idle();
    write_dim(REG_ACTIVE_WIDTH, DimW'(3));
    write_dim(REG_ACTIVE_HEIGHT, DimW'(0));
    send_frame(3, 4, 0);
    wait_idle();
    // a width held at its maximum keeps these beats in the first row, so none gives a result
    write_dim(REG_ACTIVE_WIDTH, DimW'(2047));
    send_frame(12, 0, 0);
  endtask

  task automatic test_random_frames(input int beat_target);
    int   first_beat;
    int   w;
    int   h;
    logic whole;
    first_beat = beats_sent;
    whole      = 1'b0;
    w          = 1;
    h          = 1;
    while (beats_sent - first_beat < beat_target) begin
      // a cut-off frame is always followed by a fresh setting
      if (!whole || $urandom_range(3) != 0) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
        h = $urandom_range(8, 1);
        wait_idle();
        write_dim(REG_ACTIVE_WIDTH, DimW'(w));
        write_dim(REG_ACTIVE_HEIGHT, DimW'(h));
      end
      if ($urandom_range(9) == 0) begin
        send_frame($urandom_range(w * h), 0, 5);
        whole = 1'b0;
      end else begin
        send_frame(w * h, w + 1, 3);
        whole = 1'b1;
      end
    end
  endtask

  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_ch.ready = 1'b0;
      rx_hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (sharpened_due.size() == 0) begin
        $error("out_pixel: unexpected beat, actual %0d", out_ch.out_pixel);
        fail_count++;
      end else begin
        head_res = sharpened_due.pop_front();
        if (out_ch.out_pixel !== head_res.out_pixel) begin
          $error("out_pixel: expected %0d, actual %0d", head_res.out_pixel, out_ch.out_pixel);
          fail_count++;
        end
        if (out_ch.last_of_frame !== head_res.last_of_frame) begin
          $error("last_of_frame: expected %0b, actual %0b",
                 head_res.last_of_frame, out_ch.last_of_frame);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = REG_ACTIVE_WIDTH;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_PIXEL;
    in_ch.pixel    = '0;
    out_ch.ready   = 1'b0;
    for (int i = 0; i < MaxWidth; i++) begin
      upper_row_mem[i]  = '0;
      middle_row_mem[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        tap_window[r][k] = '0;
    width_now  = MaxWidth;
    height_now = MaxHeight;
    at_col     = 0;
    at_row     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    tx_idle_pct = 22;
    rx_idle_pct = 85;
    test_directed_extremes();
    test_mid_frame_restart();
    test_back_to_back_frames();
    test_random_frames(290);

    tx_idle_pct = 85;
    rx_idle_pct = 22;
    test_random_frames(290);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_input_stall();
    test_dimension_clamping();
    test_random_frames(290);

    wait_idle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
